[rtl/sha1bs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 byte stream hasher package
// Shared types, command/status structs and algorithm constants.
// ---------------------------------------------------------------------------
package sha1bs_pkg;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   // Source of the byte pushed into the block buffer.
   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_PAD_MARK,
      SRC_ZERO,
      SRC_LENGTH
   } byte_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         push;
      byte_src_type src;
      logic         count;
      logic         start;
      logic         round;
      logic         fold;
      logic         out_step;
      logic         clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic block_full;
      logic at_length;
      logic round_last;
      logic out_last;
   } status_type;

   // Initial chaining values.
   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hefcdab89;
   localparam logic [31:0] H2 = 32'h98badcfe;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hc3d2e1f0;

   // Round constants.
   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [5:0] LAST_POS   = 6'd63;
   localparam logic [5:0] LENGTH_POS = 6'd56;

   localparam logic [6:0] ROUND_STAGE1 = 7'd20;
   localparam logic [6:0] ROUND_STAGE2 = 7'd40;
   localparam logic [6:0] ROUND_STAGE3 = 7'd60;
   localparam logic [6:0] LAST_ROUND   = 7'd79;

   localparam logic [2:0] LAST_WORD_INDEX = 3'd4;

endpackage
`default_nettype wire

[rtl/sha1bs_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 byte stream hasher channels
// Valid/ready interfaces for the byte request and the digest response.
// ---------------------------------------------------------------------------

// Request channel: one message byte per word.
interface sha1bs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output has_byte,
                   output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input has_byte,
                   input end_of_message, output ready);
endinterface

// Response channel: one digest word per word.
interface sha1bs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface
`default_nettype wire

[rtl/sha1_byte_stream_hasher_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// A message byte is taken while idle; every 64th byte starts a compression
// (80 rounds through the single round unit, then a chaining add).
// End of message: the padding and length bytes (up to 72) are pushed, with one
// or two compressions, then the five digest words go out.
// New request words are taken only while idle; one digest word per cycle while ready is high.
// Reset: synchronous; chaining words to the initial values, counters to zero.
// ---------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Hashes a byte stream with SHA-1 and returns the digest as five words.
// ---------------------------------------------------------------------------
module sha1_byte_stream_hasher_unit (
   input  wire          clock,
   input  wire          reset,
   sha1bs_req_if.sink   req_ch,
   sha1bs_rsp_if.source rsp_ch
);
   import sha1bs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   sha1bs_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_ch.valid),
      .req_has_byte       (req_ch.has_byte),
      .req_end_of_message (req_ch.end_of_message),
      .req_ready          (req_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .status             (status),
      .cmd                (cmd)
   );

   // Hash datapath.
   sha1bs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .data_byte   (req_ch.data_byte),
      .digest_word (rsp_ch.digest_word),
      .word_index  (rsp_ch.word_index),
      .last_word   (rsp_ch.last_word)
   );

endmodule
`default_nettype wire

[rtl/sha1bs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 byte stream hasher controller
// Sequences byte intake, padding, length append, compression and output.
// ---------------------------------------------------------------------------
module sha1bs_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_has_byte,
   input  wire                    req_end_of_message,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  sha1bs_pkg::status_type status,
   output sha1bs_pkg::cmd_type    cmd
);
   import sha1bs_pkg::*;

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;
   logic      pad_first_ff, pad_first_in;
   logic      len_done_ff, len_done_in;

   // State and flag registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fin_ff       <= 1'b0;
         pad_first_ff <= 1'b0;
         len_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_ff       <= fin_in;
         pad_first_ff <= pad_first_in;
         len_done_ff  <= len_done_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      pad_first_in = pad_first_ff;
      len_done_in  = len_done_ff;
      cmd          = '0;
      cmd.src      = SRC_INPUT;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               fin_in       = req_end_of_message;
               pad_first_in = 1'b1;
               len_done_in  = 1'b0;
               if (req_has_byte) begin
                  cmd.push  = 1'b1;
                  cmd.src   = SRC_INPUT;
                  cmd.count = 1'b1;
               end
               if (req_has_byte && status.block_full) begin
                  cmd.start = 1'b1;
                  state_in  = ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // Zero fill stops where the length field begins.
            if (!pad_first_ff && status.at_length) begin
               state_in = ST_LEN;
            end else begin
               cmd.push     = 1'b1;
               cmd.src      = pad_first_ff ? SRC_PAD_MARK : SRC_ZERO;
               pad_first_in = 1'b0;
               if (status.block_full) begin
                  cmd.start = 1'b1;
                  state_in  = ST_ROUND;
               end
            end
         end
         ST_LEN: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_LENGTH;
            if (status.block_full) begin
               cmd.start   = 1'b1;
               len_done_in = 1'b1;
               state_in    = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (status.round_last) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (len_done_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.out_step = 1'b1;
               if (status.out_last) begin
                  cmd.clear = 1'b1;
                  fin_in    = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/sha1bs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 byte stream hasher datapath
// Block buffer with rolling schedule, round unit, chaining words and counters.
// ---------------------------------------------------------------------------
module sha1bs_datapath (
   input  wire                    clock,
   input  wire                    reset,
   input  sha1bs_pkg::cmd_type    cmd,
   output sha1bs_pkg::status_type status,
   input  wire  [7:0]             data_byte,
   output logic [31:0]            digest_word,
   output logic [2:0]             word_index,
   output logic                   last_word
);
   import sha1bs_pkg::*;

   logic [23:0] acc_ff, acc_in;
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] bit_count_ff, bit_count_in;
   logic [31:0] chain_ff [5];
   logic [31:0] chain_in [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   logic [7:0]  byte_sel;
   logic [63:0] len_shifted;
   logic [31:0] sched_x;
   logic [31:0] sched_word;
   logic [31:0] new_word;
   logic        shift_word;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] temp;

   // Byte source selection; the length goes out big-endian by byte position.
   always_comb begin
      len_shifted = bit_count_ff >> {3'd7 - pos_ff[2:0], 3'b000};
      case (cmd.src)
         SRC_INPUT:    byte_sel = data_byte;
         SRC_PAD_MARK: byte_sel = PAD_MARK;
         SRC_ZERO:     byte_sel = 8'h00;
         SRC_LENGTH:   byte_sel = len_shifted[7:0];
         default:      byte_sel = 8'h00;
      endcase
   end

   // Message schedule word from the rolling window.
   assign sched_x    = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   assign sched_word = {sched_x[30:0], sched_x[31]};
   assign shift_word = (cmd.push && (pos_ff[1:0] == 2'b11)) || cmd.round;
   assign new_word   = cmd.round ? sched_word : {acc_ff, byte_sel};

   // Byte packer and block window.
   always_comb begin
      acc_in = acc_ff;
      w_in   = w_ff;
      if (cmd.push) begin
         acc_in = {acc_ff[15:0], byte_sel};
      end
      if (shift_word) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = new_word;
      end
   end

   // Round function and constant by round range.
   always_comb begin
      if (round_ff < ROUND_STAGE1) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K0;
      end else if (round_ff < ROUND_STAGE2) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K1;
      end else if (round_ff < ROUND_STAGE3) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K3;
      end
      temp = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_ff[0];
   end

   // Working variables and round counter.
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      round_in = round_ff;
      if (cmd.start) begin
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         e_in     = chain_ff[4];
         round_in = '0;
      end else if (cmd.round) begin
         a_in     = temp;
         b_in     = a_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         d_in     = c_ff;
         e_in     = d_ff;
         round_in = round_ff + 7'd1;
      end
   end

   // Chaining words, length counter, byte position and output index.
   always_comb begin
      chain_in     = chain_ff;
      bit_count_in = bit_count_ff;
      pos_in       = pos_ff;
      out_idx_in   = out_idx_ff;
      if (cmd.fold) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
      if (cmd.push) begin
         pos_in = pos_ff + 6'd1;
      end
      if (cmd.push && cmd.count) begin
         bit_count_in = bit_count_ff + 64'd8;
      end
      if (cmd.out_step) begin
         out_idx_in = out_idx_ff + 3'd1;
      end
      if (cmd.clear) begin
         chain_in[0]  = H0;
         chain_in[1]  = H1;
         chain_in[2]  = H2;
         chain_in[3]  = H3;
         chain_in[4]  = H4;
         bit_count_in = '0;
         pos_in       = '0;
         out_idx_in   = '0;
      end
   end

   // Registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff[0]  <= H0;
         chain_ff[1]  <= H1;
         chain_ff[2]  <= H2;
         chain_ff[3]  <= H3;
         chain_ff[4]  <= H4;
         bit_count_ff <= '0;
         pos_ff       <= '0;
         out_idx_ff   <= '0;
         round_ff     <= '0;
      end else begin
         chain_ff     <= chain_in;
         bit_count_ff <= bit_count_in;
         pos_ff       <= pos_in;
         out_idx_ff   <= out_idx_in;
         round_ff     <= round_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      w_ff   <= w_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

   // Digest word selection.
   always_comb begin
      case (out_idx_ff)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         3'd4:    digest_word = chain_ff[4];
         default: digest_word = chain_ff[0];
      endcase
   end

   assign word_index = out_idx_ff;
   assign last_word  = (out_idx_ff == LAST_WORD_INDEX);

   // Status back to the controller.
   assign status.block_full = (pos_ff == LAST_POS);
   assign status.at_length  = (pos_ff == LENGTH_POS);
   assign status.round_last = (round_ff == LAST_ROUND);
   assign status.out_last   = (out_idx_ff == LAST_WORD_INDEX);

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Feeds byte messages with random gaps and random output stalls, predicts
// the digest of each message with a SHA-1 model of its own, and checks
// every digest word in order. No external files; runs with any seed.
// ---------------------------------------------------------------------------
module tb_top;

   localparam real CLOCK_PERIOD = 12.0;
   localparam int  RESET_CYCLES = 9;
   localparam int  CYCLE_LIMIT  = 300000;
   localparam int  SETTLE_CYCLES = 300;
   localparam int  HOLD_CYCLES  = 500;
   localparam int  DIGEST_WORDS = 5;

   // SHA-1 initial chaining values and round constants.
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hc3d2e1f0;
   localparam logic [31:0] RC0 = 32'h5a827999;
   localparam logic [31:0] RC1 = 32'h6ed9eba1;
   localparam logic [31:0] RC2 = 32'h8f1bbcdc;
   localparam logic [31:0] RC3 = 32'hca62c1d6;
   localparam logic [7:0]  END_MARK_BYTE = 8'h80;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_COUNT} fill_kind_type;
   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_entry_type;

   logic clock;
   logic reset;

   sha1bs_req_if req_bus ();
   sha1bs_rsp_if rsp_bus ();

   sha1_byte_stream_hasher_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Hash state of the prediction.
   logic [31:0] chain_words [5];
   logic [31:0] block_buf [16];
   logic [63:0] message_bits;
   logic [5:0]  block_fill;

   digest_entry_type expected_digest_words [$];

   int          error_count   = 0;
   int          bytes_sent    = 0;
   int          messages_sent = 0;
   int          words_checked = 0;
   int          cycle_count   = 0;
   int          hold_requests = 0;
   int          hold_seen     = 0;
   int          hold_left     = 0;
   int          burst_left    = 0;
   int          rx_phase      = 0;
   bit          steady_sender = 1'b0;
   rx_mode_type rx_mode       = RX_ALWAYS;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2.0) clock = ~clock;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Chaining words and counters go back to their start values.
   function automatic void restart_digest();
      chain_words[0] = IV0;
      chain_words[1] = IV1;
      chain_words[2] = IV2;
      chain_words[3] = IV3;
      chain_words[4] = IV4;
      message_bits   = '0;
      block_fill     = '0;
   endfunction

   // Bytes are packed big-endian into the block words.
   function automatic void place_byte(input logic [5:0] pos, input logic [7:0] value);
      int lsb;
      lsb = 8 * (3 - int'(pos[1:0]));
      block_buf[pos[5:2]][lsb +: 8] = value;
   endfunction

   // Eighty rounds over the current block with a rolling schedule.
   function automatic void compress_block();
      logic [31:0] sched [16];
      logic [31:0] a, b, c, d, e, f, k, wt, tmp;
      int          t;
      sched = block_buf;
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (t = 0; t < 80; t++) begin
         if (t < 16) begin
            wt = sched[t];
         end else begin
            wt = rotl(sched[(t + 13) % 16] ^ sched[(t + 8) % 16] ^
                      sched[(t + 2) % 16] ^ sched[t % 16], 1);
            sched[t % 16] = wt;
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = RC0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = RC1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = RC2;
         end else begin
            f = b ^ c ^ d;
            k = RC3;
         end
         tmp = rotl(a, 5) + f + e + k + wt;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = tmp;
      end
      chain_words[0] = chain_words[0] + a;
      chain_words[1] = chain_words[1] + b;
      chain_words[2] = chain_words[2] + c;
      chain_words[3] = chain_words[3] + d;
      chain_words[4] = chain_words[4] + e;
   endfunction

   // Takes one accepted request word; on the end marker it pads the message
   // and queues the five digest words.
   function automatic void absorb_item(input logic [7:0] data, input logic has,
                                       input logic eom);
      logic [5:0]       pos;
      digest_entry_type entry;
      int               i;
      if (has) begin
         place_byte(block_fill, data);
         message_bits = message_bits + 64'd8;
         block_fill   = block_fill + 6'd1;
         if (block_fill == 6'd0) compress_block();
      end
      if (!eom) return;
      pos = block_fill;
      place_byte(pos, END_MARK_BYTE);
      for (i = int'(pos) + 1; i < 64; i++) place_byte(6'(i), 8'h00);
      // No room left for the length: it goes into an extra block.
      if (pos >= 6'd56) begin
         compress_block();
         for (i = 0; i < 16; i++) block_buf[i] = '0;
      end
      block_buf[14] = message_bits[63:32];
      block_buf[15] = message_bits[31:0];
      compress_block();
      for (i = 0; i < DIGEST_WORDS; i++) begin
         entry.digest_word = chain_words[i];
         entry.word_index  = 3'(i);
         entry.last_word   = (i == DIGEST_WORDS - 1);
         expected_digest_words = {expected_digest_words, entry};
      end
      restart_digest();
   endfunction

   // Offers one request word, with bursts and random gaps unless the sender
   // is set to stream without pauses.
   task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
      int gap;
      if (!steady_sender) begin
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= data;
      req_bus.has_byte       <= has;
      req_bus.end_of_message <= eom;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      absorb_item(data, has, eom);
      if (has) bytes_sent++;
      if (eom) messages_sent++;
   endtask

   // Sender goes quiet until every digest word has come back.
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_digest_words.size() != 0);
   endtask

   // One message of the given length; the end marker rides on the last byte
   // or comes as a separate empty end word. Idle words are mixed in when idle_odds is above zero.
   task automatic send_message(input int len, input fill_kind_type fill, input bit empty_end,
                               input int idle_odds);
      int         i;
      logic [7:0] value;
      for (i = 0; i < len; i++) begin
         if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         case (fill)
            FILL_ZERO:  value = 8'h00;
            FILL_ONES:  value = 8'hff;
            FILL_COUNT: value = 8'(i);
            default:    value = 8'($urandom_range(0, 255));
         endcase
         send_item(value, 1'b1, (i == len - 1) && !empty_end);
      end
      if (len == 0 || empty_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Empty message, idle words, byte with end marker, extreme byte values.
   task automatic test_directed_cases();
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'ha5, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_message(3, FILL_ONES, 1'b1, 0);
      send_message(1, FILL_ZERO, 1'b0, 0);
      send_item(8'h12, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h34, 1'b1, 1'b1);
      // Two empty messages back to back: the state must restart each time.
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b0, 1'b1);
      wait_until_drained();
   endtask

   // Lengths that push the length field into a second block, or end exactly
   // on a block boundary.
   task automatic test_block_boundaries();
      int lengths [$];
      lengths = {56, 64};
      lengths.shuffle();
      foreach (lengths[idx]) begin
         steady_sender = (idx == 0);
         send_message(lengths[idx], FILL_RANDOM, 1'($urandom_range(0, 1)), 16);
      end
      steady_sender = 1'b0;
      wait_until_drained();
   endtask

   // Mostly short messages with random content, end style and idle words.
   task automatic test_random_messages();
      int            first_count;
      int            len;
      fill_kind_type fill;
      first_count = bytes_sent;
      while (bytes_sent - first_count < 25) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         case ($urandom_range(0, 5))
            0:       fill = FILL_ZERO;
            1:       fill = FILL_ONES;
            2:       fill = FILL_COUNT;
            default: fill = FILL_RANDOM;
         endcase
         if ($urandom_range(0, 9) == 0) wait_until_drained();
         send_message(len, fill, 1'($urandom_range(0, 1)), 8);
      end
      wait_until_drained();
   endtask

   // The receiver holds off for a long stretch while short messages keep
   // coming, so the block backs up and stops taking bytes.
   task automatic test_result_backpressure();
      hold_requests <= hold_requests + 1;
      steady_sender = 1'b1;
      repeat (6) send_message($urandom_range(1, 4), FILL_RANDOM, 1'($urandom_range(0, 1)), 0);
      steady_sender = 1'b0;
      wait_until_drained();
   endtask

   // Receiver: checks each accepted digest word and plans the next ready.
   always @(posedge clock) begin
      digest_entry_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_digest_words.size() == 0) begin
               $error("unexpected digest word %h at index %0d",
                      rsp_bus.digest_word, rsp_bus.word_index);
               error_count++;
            end else begin
               want = expected_digest_words.pop_front();
               words_checked++;
               if (rsp_bus.digest_word !== want.digest_word) begin
                  $error("digest_word: expected %h, got %h",
                         want.digest_word, rsp_bus.digest_word);
                  error_count++;
               end
               if (rsp_bus.word_index !== want.word_index) begin
                  $error("word_index: expected %0d, got %0d",
                         want.word_index, rsp_bus.word_index);
                  error_count++;
               end
               if (rsp_bus.last_word !== want.last_word) begin
                  $error("last_word: expected %0d, got %0d",
                         want.last_word, rsp_bus.last_word);
                  error_count++;
               end
            end
         end
         // Stall schedule: the mode changes now and then; a requested
         // hold-off overrides it.
         rx_phase++;
         if (rx_phase % 200 == 0) rx_mode = rx_mode_type'($urandom_range(0, 2));
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS: rsp_bus.ready <= 1'b1;
               RX_RANDOM: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               default:   rsp_bus.ready <= (rx_phase % 7 != 2) && (rx_phase % 7 != 5);
            endcase
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL sha1_byte_stream_hasher_unit");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      req_bus.valid          <= 1'b0;
      req_bus.data_byte      <= 8'h00;
      req_bus.has_byte       <= 1'b0;
      req_bus.end_of_message <= 1'b0;
      reset                  <= 1'b1;
      foreach (block_buf[i]) block_buf[i] = '0;
      restart_digest();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_block_boundaries();
      test_random_messages();
      test_result_backpressure();

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Hashed %0d messages (%0d bytes); %0d digest words checked.",
               messages_sent, bytes_sent, words_checked);
      $display("Run had empty and one-byte messages, one- and two-block padding %s",
               "and a long output stall.");
      if (error_count == 0) begin
         $display("PASS sha1_byte_stream_hasher_unit");
      end else begin
         $display("FAIL sha1_byte_stream_hasher_unit");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/sha1bs_pkg.sv
rtl/sha1bs_if.sv
rtl/sha1bs_ctrl.sv
rtl/sha1bs_datapath.sv
rtl/sha1_byte_stream_hasher_unit.sv
bench/tb_top.sv
